FILE: design/bdq_pkg.sv
package bdq_pkg;

  typedef enum logic [3:0] {
    REQ_PUSH_HEAD = 4'd0,
    REQ_PUSH_TAIL = 4'd1,
    REQ_POP_HEAD  = 4'd2,
    REQ_POP_TAIL  = 4'd3,
    REQ_CLEAR     = 4'd4,
    REQ_FIND      = 4'd5,
    REQ_READ_AT   = 4'd6,
    REQ_MIDDLE    = 4'd7,
    REQ_REVERSE   = 4'd8
  } req_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_ROTATE,
    CELL_PUSH_FRONT,
    CELL_WRITE_AT
  } cell_op_t;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  typedef enum logic [1:0] {
    SCAN_FIND,
    SCAN_READ,
    SCAN_POP_BACK
  } scan_kind_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic [5:0]  found_position;
    logic [1:0]  status;
    logic [6:0]  entry_count;
  } result_t;

endpackage

FILE: design/bdq_cell.sv
module bdq_cell #(
  parameter int WORD_BITS = 32,
  parameter int IDX_BITS  = 6,
  parameter int CELL_IDX  = 0
) (
  input  logic                 clk,
  input  bdq_pkg::cell_op_t    op,
  input  logic [IDX_BITS-1:0]  wr_idx,
  input  logic [WORD_BITS-1:0] load_word,
  input  logic [WORD_BITS-1:0] left_word,
  input  logic [WORD_BITS-1:0] right_word,
  output logic [WORD_BITS-1:0] word
);

  logic [WORD_BITS-1:0] word_r;
  logic [WORD_BITS-1:0] word_nxt;

  always_comb begin
    word_nxt = word_r;
    unique case (op)
      bdq_pkg::CELL_HOLD: begin
        word_nxt = word_r;
      end
      bdq_pkg::CELL_ROTATE: begin
        word_nxt = right_word;
      end
      bdq_pkg::CELL_PUSH_FRONT: begin
        word_nxt = (CELL_IDX == 0) ? load_word : left_word;
      end
      bdq_pkg::CELL_WRITE_AT: begin
        word_nxt = (wr_idx == IDX_BITS'(CELL_IDX)) ? load_word : word_r;
      end
      default: begin
        word_nxt = word_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;

endmodule

FILE: design/bounded_deque_with_search.sv
// Bounded double-ended queue of signed words held in a ring of DEPTH cells, with cell 0 as the
// physical front. Push at either end, pop from the physical front, clear, reverse and any
// rejected request finish in the cycle of acceptance, and their result is registered. Find, read
// at, middle and pop from the physical tail rotate the whole ring once past cell 0 in the scan
// state and then register the result; the ring is back in place when the result appears. One
// request is worked on at a time, and one further request is taken while a finished result waits
// at the output. There is no clearing pass after reset.
module bounded_deque_with_search #(
  parameter int DEPTH     = 64,
  parameter int WORD_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         in_req_type,
  input  logic signed [31:0] in_value,
  input  logic [5:0]         in_position,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_read_value,
  output logic [5:0]         out_found_position,
  output logic [1:0]         out_status,
  output logic [6:0]         out_entry_count
);

  localparam int IDX_BITS = $clog2(DEPTH);
  localparam int CNT_BITS = $clog2(DEPTH + 1);
  localparam int CMP_BITS = (CNT_BITS > 6) ? CNT_BITS : 6;

  logic [WORD_BITS-1:0] cell_word [DEPTH];
  bdq_pkg::cell_op_t    cell_op;
  logic [IDX_BITS-1:0]  wr_idx;
  logic [WORD_BITS-1:0] word_in;
  logic [31:0]          front_32;

  bdq_pkg::state_t     state_r, state_nxt;
  bdq_pkg::scan_kind_t kind_r, kind_nxt;
  logic [CNT_BITS-1:0] count_r, count_nxt;
  logic                rev_r, rev_nxt;
  logic [IDX_BITS-1:0] k_r, k_nxt;
  logic [IDX_BITS-1:0] tgt_r, tgt_nxt;
  logic [IDX_BITS-1:0] fp_r, fp_nxt;
  logic                hit_r, hit_nxt;
  logic [WORD_BITS-1:0] key_r, key_nxt;
  logic [31:0]         rv_r, rv_nxt;

  logic                out_valid_r, out_valid_nxt;
  bdq_pkg::result_t    out_r, out_nxt;
  logic                pend_r, pend_nxt;
  bdq_pkg::result_t    pend_res_r, pend_res_nxt;

  logic                done;
  bdq_pkg::result_t    res;
  logic                accept;
  logic                front;
  logic                last;
  logic [CNT_BITS-1:0] mid;
  logic [CNT_BITS-1:0] pos_c;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      localparam int LEFT  = (gi == 0) ? DEPTH - 1 : gi - 1;
      localparam int RIGHT = (gi == DEPTH - 1) ? 0 : gi + 1;
      bdq_cell #(
        .WORD_BITS(WORD_BITS),
        .IDX_BITS (IDX_BITS),
        .CELL_IDX (gi)
      ) u_cell (
        .clk       (clk),
        .op        (cell_op),
        .wr_idx    (wr_idx),
        .load_word (word_in),
        .left_word (cell_word[LEFT]),
        .right_word(cell_word[RIGHT]),
        .word      (cell_word[gi])
      );
    end
    if (WORD_BITS >= 32) begin : g_wide
      assign word_in  = WORD_BITS'($signed(in_value));
      assign front_32 = cell_word[0][31:0];
    end else begin : g_narrow
      assign word_in  = in_value[WORD_BITS-1:0];
      assign front_32 = {{(32 - WORD_BITS){cell_word[0][WORD_BITS-1]}}, cell_word[0]};
    end
  endgenerate

  assign accept = in_valid && in_ready;
  assign in_ready = (state_r == bdq_pkg::S_IDLE) && !pend_r;
  assign last = (k_r == IDX_BITS'(DEPTH - 1));
  assign mid = count_r >> 1;
  assign pos_c = CNT_BITS'(in_position);

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    count_nxt = count_r;
    rev_nxt   = rev_r;
    k_nxt     = k_r;
    tgt_nxt   = tgt_r;
    fp_nxt    = fp_r;
    hit_nxt   = hit_r;
    key_nxt   = key_r;
    rv_nxt    = rv_r;
    cell_op   = bdq_pkg::CELL_HOLD;
    wr_idx    = IDX_BITS'(count_r);
    done      = 1'b0;
    front     = 1'b0;
    res       = '0;
    unique case (state_r)
      bdq_pkg::S_IDLE: begin
        if (accept) begin
          k_nxt  = '0;
          rv_nxt = '0;
          unique case (in_req_type)
            bdq_pkg::REQ_PUSH_HEAD, bdq_pkg::REQ_PUSH_TAIL: begin
              done  = 1'b1;
              front = (in_req_type == bdq_pkg::REQ_PUSH_HEAD) != rev_r;
              if (count_r == CNT_BITS'(DEPTH)) begin
                res.status = bdq_pkg::ST_FULL;
              end else begin
                cell_op   = front ? bdq_pkg::CELL_PUSH_FRONT : bdq_pkg::CELL_WRITE_AT;
                count_nxt = count_r + 1'b1;
              end
            end
            bdq_pkg::REQ_POP_HEAD, bdq_pkg::REQ_POP_TAIL: begin
              front = (in_req_type == bdq_pkg::REQ_POP_HEAD) != rev_r;
              if (count_r == '0) begin
                done       = 1'b1;
                res.status = bdq_pkg::ST_MISS;
              end else if (front) begin
                done           = 1'b1;
                cell_op        = bdq_pkg::CELL_ROTATE;
                count_nxt      = count_r - 1'b1;
                res.read_value = front_32;
              end else begin
                state_nxt = bdq_pkg::S_SCAN;
                kind_nxt  = bdq_pkg::SCAN_POP_BACK;
                tgt_nxt   = IDX_BITS'(count_r - 1'b1);
              end
            end
            bdq_pkg::REQ_CLEAR: begin
              done      = 1'b1;
              count_nxt = '0;
              rev_nxt   = 1'b0;
            end
            bdq_pkg::REQ_FIND: begin
              state_nxt = bdq_pkg::S_SCAN;
              kind_nxt  = bdq_pkg::SCAN_FIND;
              key_nxt   = word_in;
              hit_nxt   = 1'b0;
              fp_nxt    = '0;
            end
            bdq_pkg::REQ_READ_AT: begin
              if (CMP_BITS'(in_position) >= CMP_BITS'(count_r)) begin
                done       = 1'b1;
                res.status = bdq_pkg::ST_MISS;
              end else begin
                state_nxt = bdq_pkg::S_SCAN;
                kind_nxt  = bdq_pkg::SCAN_READ;
                fp_nxt    = IDX_BITS'(pos_c);
                tgt_nxt   = rev_r ? IDX_BITS'(count_r - 1'b1 - pos_c) : IDX_BITS'(pos_c);
              end
            end
            bdq_pkg::REQ_MIDDLE: begin
              if (count_r == '0) begin
                done       = 1'b1;
                res.status = bdq_pkg::ST_MISS;
              end else begin
                state_nxt = bdq_pkg::S_SCAN;
                kind_nxt  = bdq_pkg::SCAN_READ;
                fp_nxt    = IDX_BITS'(mid);
                tgt_nxt   = rev_r ? IDX_BITS'(count_r - 1'b1 - mid) : IDX_BITS'(mid);
              end
            end
            bdq_pkg::REQ_REVERSE: begin
              done    = 1'b1;
              rev_nxt = !rev_r;
            end
            default: begin
              done       = 1'b1;
              res.status = bdq_pkg::ST_MISS;
            end
          endcase
        end
      end
      bdq_pkg::S_SCAN: begin
        cell_op = bdq_pkg::CELL_ROTATE;
        k_nxt   = last ? '0 : k_r + 1'b1;
        if (kind_r == bdq_pkg::SCAN_FIND) begin
          if ((CNT_BITS'(k_r) < count_r) && (cell_word[0] == key_r)) begin
            if (rev_r) begin
              hit_nxt = 1'b1;
              fp_nxt  = IDX_BITS'(count_r - 1'b1 - CNT_BITS'(k_r));
            end else if (!hit_r) begin
              hit_nxt = 1'b1;
              fp_nxt  = k_r;
            end
          end
        end else if (k_r == tgt_r) begin
          rv_nxt = front_32;
        end
        if (last) begin
          state_nxt = bdq_pkg::S_IDLE;
          done      = 1'b1;
          unique case (kind_r)
            bdq_pkg::SCAN_FIND: begin
              if (hit_nxt) begin
                res.found_position = 6'(fp_nxt);
              end else begin
                res.status = bdq_pkg::ST_MISS;
              end
            end
            bdq_pkg::SCAN_READ: begin
              res.read_value     = rv_nxt;
              res.found_position = 6'(fp_r);
            end
            bdq_pkg::SCAN_POP_BACK: begin
              res.read_value = rv_nxt;
              count_nxt      = count_r - 1'b1;
            end
            default: begin
              res.status = bdq_pkg::ST_MISS;
            end
          endcase
        end
      end
      default: begin
        state_nxt = bdq_pkg::S_IDLE;
      end
    endcase
    res.entry_count = 7'(count_nxt);
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    pend_nxt      = pend_r;
    pend_res_nxt  = pend_res_r;
    priority if (done) begin
      if (!out_valid_r || out_ready) begin
        out_valid_nxt = 1'b1;
        out_nxt       = res;
      end else begin
        pend_nxt     = 1'b1;
        pend_res_nxt = res;
      end
    end else if (pend_r && (!out_valid_r || out_ready)) begin
      out_valid_nxt = 1'b1;
      out_nxt       = pend_res_r;
      pend_nxt      = 1'b0;
    end else if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bdq_pkg::S_IDLE;
      count_r     <= '0;
      rev_r       <= 1'b0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rev_r       <= rev_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    tgt_r      <= tgt_nxt;
    fp_r       <= fp_nxt;
    hit_r      <= hit_nxt;
    key_r      <= key_nxt;
    rv_r       <= rv_nxt;
    out_r      <= out_nxt;
    pend_res_r <= pend_res_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_read_value     = out_r.read_value;
  assign out_found_position = out_r.found_position;
  assign out_status         = out_r.status;
  assign out_entry_count    = out_r.entry_count;

endmodule

FILE: design/bdq_checker.sv
module bdq_checker #(
  parameter int DEPTH = 64
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [3:0]  in_req_type,
  input logic [31:0] in_value,
  input logic [5:0]  in_position,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_read_value,
  input logic [5:0]  out_found_position,
  input logic [1:0]  out_status,
  input logic [6:0]  out_entry_count
);

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != bdq_pkg::ST_OK)
      |-> (out_read_value == 32'd0) && (out_found_position == 6'd0))
    else $error("non-ok result carries data");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == bdq_pkg::ST_FULL) |-> (out_entry_count == 7'(DEPTH)))
    else $error("full status with a count below the depth");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_entry_count) <= DEPTH))
    else $error("entry count beyond the depth");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready
      |=> out_valid && $stable(out_read_value) && $stable(out_status)
          && $stable(out_entry_count) && $stable(out_found_position))
    else $error("stalled result changed");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready
      |=> in_valid && $stable(in_req_type) && $stable(in_value) && $stable(in_position))
    else $error("waiting request changed");

endmodule

bind bounded_deque_with_search bdq_checker #(.DEPTH(DEPTH)) u_bdq_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .in_req_type       (in_req_type),
  .in_value          (in_value),
  .in_position       (in_position),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_read_value    (out_read_value),
  .out_found_position(out_found_position),
  .out_status        (out_status),
  .out_entry_count   (out_entry_count)
);

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int DEPTH = 64;
  localparam int IDLE_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 80;
  localparam int RANDOM_PER_PHASE = 225;
  localparam logic [3:0] REQ_UNDEF_LO = 4'd9;
  localparam logic [3:0] REQ_UNDEF_HI = 4'd15;

  typedef struct {
    logic [3:0]         code;
    logic signed [31:0] word;
    logic [5:0]         pos;
  } request_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [3:0]         in_req_type = '0;
  logic signed [31:0] in_value = '0;
  logic [5:0]         in_position = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_read_value;
  logic [5:0]         out_found_position;
  logic [1:0]         out_status;
  logic [6:0]         out_entry_count;

  request_t           request_q[$];
  bdq_pkg::result_t   reply_q[$];
  logic signed [31:0] recent_words[16];
  int                 recent_idx = 0;
  int                 send_idle_pct = 0;
  int                 recv_stall_pct = 0;
  int                 fails = 0;
  int                 idle_cycles = 0;

  logic signed [31:0] dq_store[DEPTH];
  logic [5:0]         dq_head = '0;
  logic [6:0]         dq_count = '0;
  logic               dq_reversed = 1'b0;

  bounded_deque_with_search u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_value          (in_value),
    .in_position       (in_position),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_read_value    (out_read_value),
    .out_found_position(out_found_position),
    .out_status        (out_status),
    .out_entry_count   (out_entry_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [5:0] slot_at(logic [6:0] p);
    logic [6:0] off;
    off = dq_reversed ? dq_count - 7'd1 - p : p;
    return dq_head + off[5:0];
  endfunction

  function automatic bdq_pkg::result_t deque_step(logic [3:0] code, logic signed [31:0] word,
                                                  logic [5:0] pos);
    bdq_pkg::result_t r;
    logic             front;
    logic             hit;
    logic [5:0]       idx;
    r = '0;
    r.status = bdq_pkg::ST_OK;
    hit = 1'b0;
    case (code)
      bdq_pkg::REQ_PUSH_HEAD, bdq_pkg::REQ_PUSH_TAIL: begin
        if (dq_count >= DEPTH) begin
          r.status = bdq_pkg::ST_FULL;
        end else begin
          front = (code == bdq_pkg::REQ_PUSH_HEAD) ^ dq_reversed;
          if (front) begin
            dq_head = dq_head - 6'd1;
            dq_store[dq_head] = word;
          end else begin
            idx = dq_head + dq_count[5:0];
            dq_store[idx] = word;
          end
          dq_count = dq_count + 7'd1;
        end
      end
      bdq_pkg::REQ_POP_HEAD, bdq_pkg::REQ_POP_TAIL: begin
        if (dq_count == 0) begin
          r.status = bdq_pkg::ST_MISS;
        end else begin
          front = (code == bdq_pkg::REQ_POP_HEAD) ^ dq_reversed;
          if (front) begin
            r.read_value = dq_store[dq_head];
            dq_head = dq_head + 6'd1;
          end else begin
            idx = dq_head + dq_count[5:0] - 6'd1;
            r.read_value = dq_store[idx];
          end
          dq_count = dq_count - 7'd1;
        end
      end
      bdq_pkg::REQ_CLEAR: begin
        dq_head = '0;
        dq_count = '0;
        dq_reversed = 1'b0;
      end
      bdq_pkg::REQ_FIND: begin
        r.status = bdq_pkg::ST_MISS;
        for (int i = 0; i < dq_count; i++) begin
          if (!hit && dq_store[slot_at(7'(i))] == word) begin
            hit = 1'b1;
            r.found_position = 6'(i);
            r.status = bdq_pkg::ST_OK;
          end
        end
      end
      bdq_pkg::REQ_READ_AT: begin
        if (pos >= dq_count) begin
          r.status = bdq_pkg::ST_MISS;
        end else begin
          r.read_value = dq_store[slot_at({1'b0, pos})];
          r.found_position = pos;
        end
      end
      bdq_pkg::REQ_MIDDLE: begin
        if (dq_count == 0) begin
          r.status = bdq_pkg::ST_MISS;
        end else begin
          r.found_position = 6'(dq_count >> 1);
          r.read_value = dq_store[slot_at(dq_count >> 1)];
        end
      end
      bdq_pkg::REQ_REVERSE: begin
        dq_reversed = ~dq_reversed;
      end
      default: begin
        r.status = bdq_pkg::ST_MISS;
      end
    endcase
    r.entry_count = dq_count;
    return r;
  endfunction

  task automatic add_request(logic [3:0] code, logic signed [31:0] word, logic [5:0] pos);
    request_t item;
    item.code = code;
    item.word = word;
    item.pos = pos;
    request_q.push_back(item);
    if (code == bdq_pkg::REQ_PUSH_HEAD || code == bdq_pkg::REQ_PUSH_TAIL) begin
      recent_words[recent_idx] = word;
      recent_idx = (recent_idx + 1) % 16;
    end
  endtask

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return -32'sd1;
      3: return 32'sd0;
      4, 5: return recent_words[$urandom_range(0, 15)];
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [5:0] rand_pos();
    return $urandom_range(0, 1) ? 6'($urandom_range(0, 15)) : 6'($urandom_range(0, 63));
  endfunction

  task automatic add_push();
    add_request($urandom_range(0, 1) ? bdq_pkg::REQ_PUSH_HEAD : bdq_pkg::REQ_PUSH_TAIL,
                rand_word(), rand_pos());
  endtask

  task automatic add_pop();
    add_request($urandom_range(0, 1) ? bdq_pkg::REQ_POP_HEAD : bdq_pkg::REQ_POP_TAIL,
                rand_word(), rand_pos());
  endtask

  task automatic add_query();
    case ($urandom_range(0, 2))
      0: add_request(bdq_pkg::REQ_FIND,
                     ($urandom_range(0, 9) < 7) ? recent_words[$urandom_range(0, 15)]
                                                : rand_word(), rand_pos());
      1: add_request(bdq_pkg::REQ_READ_AT, rand_word(), rand_pos());
      default: add_request(bdq_pkg::REQ_MIDDLE, rand_word(), rand_pos());
    endcase
  endtask

  task automatic add_random(int n);
    int made;
    int len;
    made = 0;
    while (made < n) begin
      case ($urandom_range(0, 9))
        0: begin
          len = 70;
          for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0) add_query();
            else add_push();
          end
        end
        1, 2: begin
          len = $urandom_range(4, 20);
          for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 4) != 0) add_push();
            else add_query();
          end
        end
        3, 4: begin
          len = $urandom_range(4, 20);
          for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 4) != 0) add_pop();
            else add_query();
          end
        end
        5, 6, 7: begin
          len = $urandom_range(4, 15);
          for (int i = 0; i < len; i++) add_query();
        end
        8: begin
          len = $urandom_range(4, 12);
          for (int i = 0; i < len; i++) begin
            add_request(4'($urandom_range(bdq_pkg::REQ_PUSH_HEAD, bdq_pkg::REQ_REVERSE)),
                        rand_word(), rand_pos());
          end
        end
        default: begin
          len = 1;
          case ($urandom_range(0, 2))
            0: add_request(bdq_pkg::REQ_CLEAR, rand_word(), rand_pos());
            1: add_request(bdq_pkg::REQ_REVERSE, rand_word(), rand_pos());
            default: add_request(4'($urandom_range(REQ_UNDEF_LO, REQ_UNDEF_HI)), rand_word(),
                                 rand_pos());
          endcase
        end
      endcase
      made += len;
    end
  endtask

  task automatic add_directed();
    add_request(bdq_pkg::REQ_POP_HEAD, 32'sd0, 6'd0);
    add_request(bdq_pkg::REQ_POP_TAIL, 32'sd0, 6'd0);
    add_request(bdq_pkg::REQ_MIDDLE, 32'sd0, 6'd0);
    add_request(bdq_pkg::REQ_FIND, 32'sd0, 6'd0);
    add_request(bdq_pkg::REQ_REVERSE, 32'sd0, 6'd0);
    add_request(bdq_pkg::REQ_PUSH_HEAD, 32'sh7fff_ffff, 6'd63);
    add_request(bdq_pkg::REQ_PUSH_TAIL, 32'sh8000_0000, 6'd0);
    add_request(bdq_pkg::REQ_PUSH_HEAD, -32'sd1, 6'd0);
    add_request(bdq_pkg::REQ_PUSH_TAIL, 32'sd0, 6'd0);
    add_request(bdq_pkg::REQ_FIND, -32'sd1, 6'd0);
    add_request(bdq_pkg::REQ_FIND, 32'sd12345, 6'd0);
    add_request(bdq_pkg::REQ_READ_AT, 32'sd0, 6'd0);
    add_request(bdq_pkg::REQ_READ_AT, 32'sd0, 6'd3);
    add_request(bdq_pkg::REQ_READ_AT, 32'sd0, 6'd4);
    add_request(bdq_pkg::REQ_READ_AT, -32'sd1, 6'd63);
    add_request(bdq_pkg::REQ_MIDDLE, 32'sd0, 6'd0);
    add_request(bdq_pkg::REQ_REVERSE, 32'sd0, 6'd0);
    add_request(bdq_pkg::REQ_READ_AT, 32'sd0, 6'd0);
    add_request(bdq_pkg::REQ_POP_HEAD, 32'sd0, 6'd0);
    add_request(bdq_pkg::REQ_POP_TAIL, 32'sd0, 6'd0);
    add_request(REQ_UNDEF_LO, 32'sd0, 6'd0);
    add_request(REQ_UNDEF_HI, -32'sd1, 6'd63);
    add_request(bdq_pkg::REQ_CLEAR, 32'sd0, 6'd0);
    add_request(bdq_pkg::REQ_READ_AT, 32'sd0, 6'd0);
  endtask

  always @(posedge clk) begin : drive_requests
    request_t item;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        reply_q.push_back(deque_step(in_req_type, in_value, in_position));
      end
      if (!in_valid || in_ready) begin
        if (request_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          item = request_q.pop_front();
          in_valid <= 1'b1;
          in_req_type <= item.code;
          in_value <= item.word;
          in_position <= item.pos;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_replies
    bdq_pkg::result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      if (out_valid && out_ready) begin
        if (reply_q.size() == 0) begin
          $display("%0t: reply with no request pending: value %0d position %0d status %0d",
                   $time, out_read_value, out_found_position, out_status);
          fails++;
        end else begin
          want = reply_q.pop_front();
          if (out_read_value !== want.read_value) begin
            $display("%0t: read_value expected %0d, got %0d", $time,
                     $signed(want.read_value), out_read_value);
            fails++;
          end
          if (out_found_position !== want.found_position) begin
            $display("%0t: found_position expected %0d, got %0d", $time,
                     want.found_position, out_found_position);
            fails++;
          end
          if (out_status !== want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status, out_status);
            fails++;
          end
          if (out_entry_count !== want.entry_count) begin
            $display("%0t: entry_count expected %0d, got %0d", $time,
                     want.entry_count, out_entry_count);
            fails++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    for (int i = 0; i < 16; i++) recent_words[i] = '0;
    for (int i = 0; i < DEPTH; i++) dq_store[i] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          add_directed();
        end
        1: begin
          send_idle_pct = 74;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 74;
        end
        default: begin
          send_idle_pct = 36;
          recv_stall_pct = 36;
        end
      endcase
      add_random(RANDOM_PER_PHASE);
      while (request_q.size() > 0 || in_valid || reply_q.size() > 0) @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (reply_q.size() > 0) begin
      $display("%0t: %0d replies never arrived", $time, reply_q.size());
      fails++;
    end
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/bdq_pkg.sv
design/bdq_cell.sv
design/bounded_deque_with_search.sv
design/bdq_checker.sv
tb/tb.sv
